// ===== hdl/kscan_pkg.sv =====
// ----------------------------------------------------------------------------
// kscan_pkg
// Shared types and constants of the key scanner with autorepeat and queue.
// ----------------------------------------------------------------------------
package kscan_pkg;

    localparam int NUM_KEYS_DEF   = 8;
    localparam int RING_DEPTH_DEF = 16;

    localparam int KEY_LEVEL_W = 8;
    localparam int CODE_W      = 3;
    localparam int CNT_W       = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;

    // reset values of the timing registers
    localparam logic [CNT_W-1:0] RST_FIRST_DELAY   = 8'd25;
    localparam logic [CNT_W-1:0] RST_REPEAT_INTVL  = 8'd5;
    localparam logic [CNT_W-1:0] RST_RELEASE_DELAY = 8'd5;

    // operation codes
    localparam logic [1:0] OP_SCAN  = 2'd0;
    localparam logic [1:0] OP_GET   = 2'd1;
    localparam logic [1:0] OP_FLUSH = 2'd2;
    localparam logic [1:0] OP_UNGET = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_ENABLE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DELAY   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_INTVL  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_DELAY = 2'd3;

    typedef struct packed {
        logic [1:0]             op;
        logic [KEY_LEVEL_W-1:0] key_levels;
        logic [CODE_W-1:0]      pushback_code;
    } in_t;

    typedef struct packed {
        logic              key_valid;
        logic [CODE_W-1:0] key_code;
        logic              none_pressed;
    } out_t;

    // ring commands from the sequencer
    typedef struct packed {
        logic push;
        logic pop;
        logic flush;
    } ring_ctl_t;

endpackage

// ===== hdl/kscan_key_unit.sv =====
// ----------------------------------------------------------------------------
// kscan_key_unit
// Shared per-key update: press and release counters of the key being visited.
// ----------------------------------------------------------------------------
module kscan_key_unit (
    input  logic                        pressed,
    input  logic [kscan_pkg::CNT_W-1:0] press_cnt,
    input  logic [kscan_pkg::CNT_W-1:0] release_cnt,
    input  logic [kscan_pkg::CNT_W-1:0] first_delay,
    input  logic [kscan_pkg::CNT_W-1:0] repeat_intvl,
    input  logic [kscan_pkg::CNT_W-1:0] release_delay,
    output logic [kscan_pkg::CNT_W-1:0] press_cnt_new,
    output logic [kscan_pkg::CNT_W-1:0] release_cnt_new,
    output logic                        queue
);
    import kscan_pkg::*;

    logic [CNT_W-1:0] press_dec;
    logic [CNT_W-1:0] release_dec;

    assign press_dec   = press_cnt - 1'b1;
    assign release_dec = release_cnt - 1'b1;

    always_comb
    begin
        press_cnt_new   = press_cnt;
        release_cnt_new = release_cnt;
        queue           = 1'b0;
        if (pressed)
        begin
            release_cnt_new = release_delay;
            if (press_cnt == '0)
            begin
                press_cnt_new = first_delay;
                queue         = 1'b1;
            end
            else if (press_dec == '0)
            begin
                press_cnt_new = repeat_intvl;
                queue         = 1'b1;
            end
            else
            begin
                press_cnt_new = press_dec;
            end
        end
        else if (release_cnt != '0)
        begin
            release_cnt_new = release_dec;
            // key counts as released once the release count runs out
            if (release_dec == '0)
            begin
                press_cnt_new = '0;
            end
        end
    end

endmodule

// ===== hdl/kscan_ring.sv =====
// ----------------------------------------------------------------------------
// kscan_ring
// Event queue: ring memory with write and read pointers, one slot kept free.
// ----------------------------------------------------------------------------
module kscan_ring #(
    parameter int RING_DEPTH = kscan_pkg::RING_DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  kscan_pkg::ring_ctl_t         ctl,
    input  logic [kscan_pkg::CODE_W-1:0] wr_code,
    output logic [kscan_pkg::CODE_W-1:0] rd_code,
    output logic                         empty
);
    import kscan_pkg::*;

    localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

    logic [CODE_W-1:0] mem [RING_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CODE_W-1:0] rd_code_reg;
    logic [PTR_W-1:0]  wr_ptr_inc;
    logic [PTR_W-1:0]  rd_ptr_inc;
    logic              do_write;

    assign wr_ptr_inc = (wr_ptr_reg == PTR_W'(RING_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_inc = (rd_ptr_reg == PTR_W'(RING_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

    // drop the write when the ring is full
    assign do_write = ctl.push && (wr_ptr_inc != rd_ptr_reg);
    assign empty    = (rd_ptr_reg == wr_ptr_reg);
    assign rd_code  = rd_code_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_write)
        begin
            wr_ptr_next = wr_ptr_inc;
        end
        if (ctl.flush)
        begin
            rd_ptr_next = wr_ptr_reg;
        end
        else if (ctl.pop)
        begin
            rd_ptr_next = rd_ptr_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            mem[wr_ptr_reg] <= wr_code;
        end
        rd_code_reg <= mem[rd_ptr_reg];
    end

endmodule

// ===== hdl/key_scanner_autorepeat_fifo.sv =====
// ----------------------------------------------------------------------------
// key_scanner_autorepeat_fifo
// Key scanner with autorepeat, event ring, push-back key and flush.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one beat per operation (scan tick, get, flush, push back).
//   out_* : one result beat per operation: key_valid/key_code for a get
//           (zero otherwise) and none_pressed after the operation.
//   cfg_* : single-cycle register writes (scan enable and the three delays);
//           write only while no operation is in flight.
// Sequencing:
//   One operation at a time; in_ready is high only while the sequencer idles.
//   An enabled scan tick visits one key per cycle through the shared key
//   unit, then ST_FINISH loads its result. A get passes ST_GET and, when it
//   pops the ring, ST_GET_DATA (registered ring read); a get served by the
//   push-back key or finding the ring empty goes from ST_GET to ST_FINISH.
//   A flush, a push back or a disabled scan tick goes straight to ST_FINISH.
//   in_ready returns as the result is loaded into the output register.
// Reset:
//   Counters, pointers, push-back key and scan enable clear; the delays load
//   their defaults. Ring contents stay undefined until written.
// Stall:
//   The result sits in an output register; when out_ready is low the next
//   operation is still taken and its result waits until the register frees.
// ----------------------------------------------------------------------------
module key_scanner_autorepeat_fifo #(
    parameter int NUM_KEYS   = kscan_pkg::NUM_KEYS_DEF,
    parameter int RING_DEPTH = kscan_pkg::RING_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  kscan_pkg::in_t                   in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output kscan_pkg::out_t                  out_data,
    input  logic                             cfg_we,
    input  logic [kscan_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [kscan_pkg::CFG_DATA_W-1:0] cfg_data
);
    import kscan_pkg::*;

    localparam int KEY_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_GET,
        ST_GET_DATA,
        ST_FINISH
    } state_t;

    state_t                 state_reg, state_next;
    logic [KEY_W-1:0]       key_idx_reg, key_idx_next;
    logic [KEY_LEVEL_W-1:0] levels_reg, levels_next;
    logic                   res_valid_reg, res_valid_next;
    logic [CODE_W-1:0]      res_code_reg, res_code_next;
    logic                   pb_valid_reg, pb_valid_next;
    logic [CODE_W-1:0]      pb_key_reg, pb_key_next;
    logic                   out_valid_reg, out_valid_next;
    out_t                   out_data_reg, out_data_next;

    logic                   scan_en_reg;
    logic [CNT_W-1:0]       first_delay_reg;
    logic [CNT_W-1:0]       repeat_intvl_reg;
    logic [CNT_W-1:0]       release_delay_reg;

    logic [CNT_W-1:0]       press_reg   [NUM_KEYS];
    logic [CNT_W-1:0]       press_next  [NUM_KEYS];
    logic [CNT_W-1:0]       release_reg [NUM_KEYS];
    logic [CNT_W-1:0]       release_next[NUM_KEYS];
    logic [NUM_KEYS-1:0]    held_reg, held_next;

    logic                   key_pressed;
    logic [CNT_W-1:0]       press_new;
    logic [CNT_W-1:0]       release_new;
    logic                   key_queue;
    ring_ctl_t              ring_ctl;
    logic [CODE_W-1:0]      ring_rd_code;
    logic                   ring_empty;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // keys beyond the level bits read as released
    assign key_pressed = (int'(key_idx_reg) < KEY_LEVEL_W)
                         && !levels_reg[3'(key_idx_reg)];

    kscan_key_unit u_key_unit (
        .pressed         (key_pressed),
        .press_cnt       (press_reg[key_idx_reg]),
        .release_cnt     (release_reg[key_idx_reg]),
        .first_delay     (first_delay_reg),
        .repeat_intvl    (repeat_intvl_reg),
        .release_delay   (release_delay_reg),
        .press_cnt_new   (press_new),
        .release_cnt_new (release_new),
        .queue           (key_queue)
    );

    kscan_ring #(
        .RING_DEPTH (RING_DEPTH)
    ) u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ring_ctl),
        .wr_code (CODE_W'(key_idx_reg)),
        .rd_code (ring_rd_code),
        .empty   (ring_empty)
    );

    always_comb
    begin
        state_next     = state_reg;
        key_idx_next   = key_idx_reg;
        levels_next    = levels_reg;
        res_valid_next = res_valid_reg;
        res_code_next  = res_code_reg;
        pb_valid_next  = pb_valid_reg;
        pb_key_next    = pb_key_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        press_next     = press_reg;
        release_next   = release_reg;
        held_next      = held_reg;
        ring_ctl       = '0;

        case (state_reg)
            ST_IDLE:
            begin
                res_valid_next = 1'b0;
                res_code_next  = '0;
                if (in_valid)
                begin
                    levels_next = in_data.key_levels;
                    case (in_data.op)
                        OP_SCAN:
                        begin
                            key_idx_next = '0;
                            state_next   = scan_en_reg ? ST_SCAN : ST_FINISH;
                        end
                        OP_GET:
                        begin
                            state_next = ST_GET;
                        end
                        OP_FLUSH:
                        begin
                            ring_ctl.flush = 1'b1;
                            pb_valid_next  = 1'b0;
                            state_next     = ST_FINISH;
                        end
                        OP_UNGET:
                        begin
                            pb_valid_next = 1'b1;
                            pb_key_next   = in_data.pushback_code;
                            state_next    = ST_FINISH;
                        end
                        default:
                        begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                press_next[key_idx_reg]   = press_new;
                release_next[key_idx_reg] = release_new;
                held_next[key_idx_reg]    = (press_new != '0);
                ring_ctl.push             = key_queue;
                if (key_idx_reg == KEY_W'(NUM_KEYS - 1))
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    key_idx_next = key_idx_reg + 1'b1;
                end
            end
            ST_GET:
            begin
                if (pb_valid_reg)
                begin
                    res_valid_next = 1'b1;
                    res_code_next  = pb_key_reg;
                    pb_valid_next  = 1'b0;
                    state_next     = ST_FINISH;
                end
                else if (!ring_empty)
                begin
                    // wait in ST_GET_DATA for the registered ring read
                    state_next = ST_GET_DATA;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_GET_DATA:
            begin
                res_valid_next = 1'b1;
                res_code_next  = ring_rd_code;
                ring_ctl.pop   = 1'b1;
                state_next     = ST_FINISH;
            end
            ST_FINISH:
            begin
                // hold the result until the output register frees
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next              = 1'b1;
                    out_data_next.key_valid     = res_valid_reg;
                    out_data_next.key_code      = res_code_reg;
                    out_data_next.none_pressed  = ~|held_reg;
                    state_next                  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            key_idx_reg   <= '0;
            levels_reg    <= '0;
            res_valid_reg <= 1'b0;
            res_code_reg  <= '0;
            pb_valid_reg  <= 1'b0;
            pb_key_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            held_reg      <= '0;
            for (int i = 0; i < NUM_KEYS; i++)
            begin
                press_reg[i]   <= '0;
                release_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            key_idx_reg   <= key_idx_next;
            levels_reg    <= levels_next;
            res_valid_reg <= res_valid_next;
            res_code_reg  <= res_code_next;
            pb_valid_reg  <= pb_valid_next;
            pb_key_reg    <= pb_key_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            held_reg      <= held_next;
            press_reg     <= press_next;
            release_reg   <= release_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_en_reg       <= 1'b0;
            first_delay_reg   <= RST_FIRST_DELAY;
            repeat_intvl_reg  <= RST_REPEAT_INTVL;
            release_delay_reg <= RST_RELEASE_DELAY;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SCAN_ENABLE:   scan_en_reg       <= cfg_data[0];
                CFG_FIRST_DELAY:   first_delay_reg   <= cfg_data;
                CFG_REPEAT_INTVL:  repeat_intvl_reg  <= cfg_data;
                CFG_RELEASE_DELAY: release_delay_reg <= cfg_data;
                default:           scan_en_reg       <= scan_en_reg;
            endcase
        end
    end

endmodule

// ===== hdl/kscan_checker.sv =====
// ----------------------------------------------------------------------------
// kscan_checker
// Port-level checks of the key scanner, bound to the top level.
// ----------------------------------------------------------------------------
module kscan_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            in_valid,
    input logic            in_ready,
    input logic            out_valid,
    input logic            out_ready,
    input kscan_pkg::out_t out_data
);
    import kscan_pkg::*;

    // a stalled result beat holds
    property p_out_hold;
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data));
    endproperty
    a_out_hold: assert property (p_out_hold)
        else $error("result beat changed while stalled");

    // no key returned means a zero code
    property p_code_zero;
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.key_valid) |-> (out_data.key_code == '0);
    endproperty
    a_code_zero: assert property (p_code_zero)
        else $error("key code set without a returned key");

    // one operation at a time: busy right after an accepted beat
    property p_busy_after_accept;
        @(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready;
    endproperty
    a_busy_after_accept: assert property (p_busy_after_accept)
        else $error("input taken again while an operation is in flight");

endmodule

bind key_scanner_autorepeat_fifo kscan_checker u_kscan_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
